[rtl/sfcs_pkg.sv]
// Package: types, codes and helper functions of the SPI NOR flash command sequencer.
package sfcs_pkg;

	localparam int PAGE_BYTES     = 256;
	localparam int MAX_READ_BYTES = 4096;
	localparam int COUNT_W        = 13;
	localparam int POLL_W         = 10;
	localparam int CFG_IDX_W      = 4;

	localparam logic [2:0] FN_READ      = 3'd0;
	localparam logic [2:0] FN_PROGRAM   = 3'd1;
	localparam logic [2:0] FN_ERASE     = 3'd2;
	localparam logic [2:0] FN_STATUS    = 3'd3;
	localparam logic [2:0] FN_ID        = 3'd4;
	localparam logic [2:0] FN_BYTE_DONE = 3'd5;
	localparam logic [2:0] FN_WR_DATA   = 3'd6;
	localparam logic [2:0] FN_MS_TICK   = 3'd7;

	localparam logic [1:0] KIND_SPI  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROG_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE_LIMIT = CFG_IDX_W'(1);

	localparam logic [POLL_W-1:0] PROG_LIMIT_RST  = POLL_W'(5);
	localparam logic [POLL_W-1:0] ERASE_LIMIT_RST = POLL_W'(500);

	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_PP     = 8'h02;
	localparam logic [7:0] CMD_SE     = 8'h20;
	localparam logic [7:0] CMD_WREN   = 8'h06;
	localparam logic [7:0] CMD_RDSR1  = 8'h05;
	localparam logic [7:0] CMD_RDSR2  = 8'h35;
	localparam logic [7:0] CMD_RDID   = 8'h9f;
	localparam logic [7:0] BYTE_DUMMY = 8'h00;
	localparam logic [7:0] BYTE_FILL  = 8'hff;
	localparam logic [7:0] SR1_BUSY   = 8'h01;

	localparam logic [15:0] ID_PART_A = 16'h4014;
	localparam logic [15:0] ID_PART_B = 16'h4015;
	localparam logic [15:0] ID_PART_C = 16'h4017;

	typedef struct packed {
		logic [2:0]         func;
		logic [23:0]        address;
		logic [COUNT_W-1:0] length;
		logic [7:0]         tx_byte;
		logic [7:0]         rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  mosi_byte;
		logic        select_before;
		logic        release_after;
		logic [7:0]  data_byte;
		logic        success;
		logic [15:0] status_word;
		logic [15:0] part_id;
		logic        part_known;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  item0;
		out_item_t  item1;
	} push_t;

	function automatic out_item_t mk_byte(logic [7:0] b, logic sel, logic rel);
		out_item_t r;
		r               = '0;
		r.kind          = KIND_SPI;
		r.mosi_byte     = b;
		r.select_before = sel;
		r.release_after = rel;
		return r;
	endfunction

	function automatic out_item_t mk_data(logic [7:0] d);
		out_item_t r;
		r           = '0;
		r.kind      = KIND_DATA;
		r.data_byte = d;
		return r;
	endfunction

	function automatic out_item_t mk_done(logic ok, logic [15:0] sw, logic [15:0] pid,
			logic known);
		out_item_t r;
		r             = '0;
		r.kind        = KIND_DONE;
		r.success     = ok;
		r.status_word = sw;
		r.part_id     = pid;
		r.part_known  = known;
		return r;
	endfunction

endpackage

[rtl/sfcs_if.sv]
// Interfaces: command, result and configuration channels.
interface sfcs_cmd_if;
	import sfcs_pkg::*;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic [23:0]        address;
	logic [COUNT_W-1:0] length;
	logic [7:0]         tx_byte;
	logic [7:0]         rx_byte;

	modport source (output valid, func, address, length, tx_byte, rx_byte, input ready);
	modport sink (input valid, func, address, length, tx_byte, rx_byte, output ready);
endinterface

interface sfcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  mosi_byte;
	logic        select_before;
	logic        release_after;
	logic [7:0]  data_byte;
	logic        success;
	logic [15:0] status_word;
	logic [15:0] part_id;
	logic        part_known;
	logic        last;

	modport source (output valid, kind, mosi_byte, select_before, release_after, data_byte,
		success, status_word, part_id, part_known, last, input ready);
	modport sink (input valid, kind, mosi_byte, select_before, release_after, data_byte,
		success, status_word, part_id, part_known, last, output ready);
endinterface

interface sfcs_cfg_if;
	import sfcs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POLL_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/sfcs_core.sv]
// Sequencer core: phase register and per-transaction step logic.
module sfcs_core import sfcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  in_item_t          item,
	input  logic [POLL_W-1:0] prog_limit,
	input  logic [POLL_W-1:0] erase_limit,
	output push_t             push
);

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_RD_CMD   = 5'd1;
	localparam logic [4:0] PH_RD_HI    = 5'd2;
	localparam logic [4:0] PH_RD_MID   = 5'd3;
	localparam logic [4:0] PH_RD_LO    = 5'd4;
	localparam logic [4:0] PH_RD_DATA  = 5'd5;
	localparam logic [4:0] PH_WEN      = 5'd6;
	localparam logic [4:0] PH_WR_CMD   = 5'd7;
	localparam logic [4:0] PH_WR_HI    = 5'd8;
	localparam logic [4:0] PH_WR_MID   = 5'd9;
	localparam logic [4:0] PH_WR_LO    = 5'd10;
	localparam logic [4:0] PH_PG_WAIT  = 5'd11;
	localparam logic [4:0] PH_PG_DATA  = 5'd12;
	localparam logic [4:0] PH_TICK     = 5'd13;
	localparam logic [4:0] PH_POLL_CMD = 5'd14;
	localparam logic [4:0] PH_POLL_RD  = 5'd15;
	localparam logic [4:0] PH_S1_CMD   = 5'd16;
	localparam logic [4:0] PH_S1_RD    = 5'd17;
	localparam logic [4:0] PH_S2_CMD   = 5'd18;
	localparam logic [4:0] PH_S2_RD    = 5'd19;
	localparam logic [4:0] PH_ID_CMD   = 5'd20;
	localparam logic [4:0] PH_ID_B1    = 5'd21;
	localparam logic [4:0] PH_ID_B2    = 5'd22;
	localparam logic [4:0] PH_ID_B3    = 5'd23;

	localparam logic [COUNT_W-1:0] MAX_LEN = COUNT_W'(MAX_READ_BYTES);
	localparam logic [COUNT_W-1:0] PG_LEN  = COUNT_W'(PAGE_BYTES);
	localparam logic [COUNT_W-1:0] ONE_C   = COUNT_W'(1);

	logic [4:0]         phase_q, phase_d;
	logic [2:0]         op_q, op_d;
	logic [23:0]        addr_q, addr_d;
	logic [COUNT_W-1:0] byte_count_q, byte_count_d, bc_dec;
	logic [POLL_W-1:0]  polls_left_q, polls_left_d;
	logic [7:0]         held_q, held_d;
	logic [1:0]         n;
	out_item_t          r0, r1;
	logic [15:0]        pid;

	assign bc_dec = byte_count_q - ONE_C;
	assign pid    = {held_q, item.rx_byte};

	always_comb begin
		phase_d      = phase_q;
		op_d         = op_q;
		addr_d       = addr_q;
		byte_count_d = byte_count_q;
		polls_left_d = polls_left_q;
		held_d       = held_q;
		n            = 2'd0;
		r0           = '0;
		r1           = '0;
		if (item.func inside {[FN_READ:FN_ID]}) begin
			if (phase_q == PH_IDLE) begin
				op_d   = item.func;
				addr_d = item.address;
				n      = 2'd1;
				case (item.func)
					FN_READ: begin
						byte_count_d = (item.length > MAX_LEN) ? MAX_LEN : item.length;
						r0           = mk_byte(CMD_READ, 1'b1, 1'b0);
						phase_d      = PH_RD_CMD;
					end
					FN_PROGRAM, FN_ERASE: begin
						r0      = mk_byte(CMD_WREN, 1'b1, 1'b1);
						phase_d = PH_WEN;
					end
					FN_STATUS: begin
						r0      = mk_byte(CMD_RDSR1, 1'b1, 1'b0);
						phase_d = PH_S1_CMD;
					end
					default: begin
						r0      = mk_byte(CMD_RDID, 1'b1, 1'b0);
						phase_d = PH_ID_CMD;
					end
				endcase
			end
		end else if (item.func == FN_BYTE_DONE) begin
			case (phase_q)
				PH_RD_CMD: begin
					n = 2'd1; r0 = mk_byte(addr_q[23:16], 1'b0, 1'b0); phase_d = PH_RD_HI;
				end
				PH_RD_HI: begin
					n = 2'd1; r0 = mk_byte(addr_q[15:8], 1'b0, 1'b0); phase_d = PH_RD_MID;
				end
				PH_RD_MID: begin
					n       = 2'd1;
					r0      = mk_byte(addr_q[7:0], 1'b0, byte_count_q == '0);
					phase_d = PH_RD_LO;
				end
				PH_RD_LO: begin
					n = 2'd1;
					if (byte_count_q == '0) begin
						r0      = mk_done(1'b1, '0, '0, 1'b0);
						phase_d = PH_IDLE;
					end else begin
						r0      = mk_byte(BYTE_DUMMY, 1'b0, byte_count_q == ONE_C);
						phase_d = PH_RD_DATA;
					end
				end
				PH_RD_DATA: begin
					n            = 2'd2;
					r0           = mk_data(item.rx_byte);
					byte_count_d = bc_dec;
					if (bc_dec == '0) begin
						r1      = mk_done(1'b1, '0, '0, 1'b0);
						phase_d = PH_IDLE;
					end else begin
						r1 = mk_byte(BYTE_DUMMY, 1'b0, bc_dec == ONE_C);
					end
				end
				PH_WEN: begin
					n       = 2'd1;
					r0      = mk_byte((op_q == FN_PROGRAM) ? CMD_PP : CMD_SE, 1'b1, 1'b0);
					phase_d = PH_WR_CMD;
				end
				PH_WR_CMD: begin
					n = 2'd1; r0 = mk_byte(addr_q[23:16], 1'b0, 1'b0); phase_d = PH_WR_HI;
				end
				PH_WR_HI: begin
					n = 2'd1; r0 = mk_byte(addr_q[15:8], 1'b0, 1'b0); phase_d = PH_WR_MID;
				end
				PH_WR_MID: begin
					n       = 2'd1;
					r0      = mk_byte(BYTE_DUMMY, 1'b0, op_q != FN_PROGRAM);
					phase_d = PH_WR_LO;
				end
				PH_WR_LO: begin
					if (op_q == FN_PROGRAM) begin
						byte_count_d = PG_LEN;
						phase_d      = PH_PG_WAIT;
					end else begin
						polls_left_d = erase_limit;
						phase_d      = PH_TICK;
					end
				end
				PH_PG_DATA: begin
					byte_count_d = bc_dec;
					if (bc_dec == '0) begin
						polls_left_d = prog_limit;
						phase_d      = PH_TICK;
					end else begin
						phase_d = PH_PG_WAIT;
					end
				end
				PH_POLL_CMD: begin
					n = 2'd1; r0 = mk_byte(BYTE_FILL, 1'b0, 1'b1); phase_d = PH_POLL_RD;
				end
				PH_POLL_RD: begin
					if ((item.rx_byte & SR1_BUSY) == '0) begin
						n = 2'd1; r0 = mk_done(1'b1, '0, '0, 1'b0); phase_d = PH_IDLE;
					end else if (polls_left_q == '0) begin
						n = 2'd1; r0 = mk_done(1'b0, '0, '0, 1'b0); phase_d = PH_IDLE;
					end else begin
						polls_left_d = polls_left_q - POLL_W'(1);
						phase_d      = PH_TICK;
					end
				end
				PH_S1_CMD: begin
					n = 2'd1; r0 = mk_byte(BYTE_FILL, 1'b0, 1'b1); phase_d = PH_S1_RD;
				end
				PH_S1_RD: begin
					held_d  = item.rx_byte;
					n       = 2'd1;
					r0      = mk_byte(CMD_RDSR2, 1'b1, 1'b0);
					phase_d = PH_S2_CMD;
				end
				PH_S2_CMD: begin
					n = 2'd1; r0 = mk_byte(BYTE_FILL, 1'b0, 1'b1); phase_d = PH_S2_RD;
				end
				PH_S2_RD: begin
					n       = 2'd1;
					r0      = mk_done(1'b1, {item.rx_byte, held_q}, '0, 1'b0);
					phase_d = PH_IDLE;
				end
				PH_ID_CMD: begin
					n = 2'd1; r0 = mk_byte(BYTE_DUMMY, 1'b0, 1'b0); phase_d = PH_ID_B1;
				end
				PH_ID_B1: begin
					n = 2'd1; r0 = mk_byte(BYTE_DUMMY, 1'b0, 1'b0); phase_d = PH_ID_B2;
				end
				PH_ID_B2: begin
					held_d  = item.rx_byte;
					n       = 2'd1;
					r0      = mk_byte(BYTE_DUMMY, 1'b0, 1'b1);
					phase_d = PH_ID_B3;
				end
				PH_ID_B3: begin
					n       = 2'd1;
					r0      = mk_done(1'b1, '0, pid,
						(pid == ID_PART_A) || (pid == ID_PART_B) || (pid == ID_PART_C));
					phase_d = PH_IDLE;
				end
				default: begin
				end
			endcase
		end else if (item.func == FN_WR_DATA) begin
			if (phase_q == PH_PG_WAIT) begin
				n       = 2'd1;
				r0      = mk_byte(item.tx_byte, 1'b0, byte_count_q == ONE_C);
				phase_d = PH_PG_DATA;
			end
		end else begin
			if (phase_q == PH_TICK) begin
				n       = 2'd1;
				r0      = mk_byte(CMD_RDSR1, 1'b1, 1'b0);
				phase_d = PH_POLL_CMD;
			end
		end
		if (n == 2'd1)
			r0.last = 1'b1;
		if (n == 2'd2)
			r1.last = 1'b1;
	end

	assign push.cnt   = take ? n : 2'd0;
	assign push.item0 = r0;
	assign push.item1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			op_q         <= '0;
			addr_q       <= '0;
			byte_count_q <= '0;
			polls_left_q <= '0;
			held_q       <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			op_q         <= op_d;
			addr_q       <= addr_d;
			byte_count_q <= byte_count_d;
			polls_left_q <= polls_left_d;
			held_q       <= held_d;
		end
	end

	// two results only from a read data step: data byte first, last on the second
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (r0.kind == KIND_DATA && !r0.last && r1.last))
		else $error("two results without a leading data byte");

	a_busy_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q != PH_IDLE && item.func <= FN_ID) |=> (phase_q == $past(phase_q)))
		else $error("command accepted while a sequence is running");

	a_page_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_PG_DATA && item.func == FN_BYTE_DONE && byte_count_q == ONE_C)
		|=> (phase_q == PH_TICK && polls_left_q == $past(prog_limit)))
		else $error("page end did not arm the program poll budget");

endmodule

[rtl/sfcs_rsp_fifo.sv]
// Result queue: takes up to two results a cycle, hands them out one at a time in order.
module sfcs_rsp_fifo import sfcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	input  logic      pop,
	output logic      room,
	output logic      out_valid,
	output out_item_t out_item
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	out_item_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign out_valid = count_q != '0;
	assign out_item  = mem[rd_ptr_q];
	assign room      = count_q <= CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wr_ptr_q] <= push.item0;
		if (push.cnt == 2'd2)
			mem[wr_ptr_q + PTR_W'(1)] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q <= CNT_W'(DEPTH - 2)))
		else $error("result pushed without room for two");

endmodule

[rtl/spi_nor_flash_command_sequencer_top.sv]
// Top level of the SPI NOR flash command sequencer.
//  channel | role   | payload
//  cmd     | sink   | func, address, length, tx_byte, rx_byte
//  rsp     | source | kind, mosi_byte, select_before, release_after, data_byte,
//          |        | success, status_word, part_id, part_known, last
//  cfg     | sink   | index, data (poll limits, always ready)
// One transaction per cycle enters an input register while the result queue has room.
// A read data step gives two results, so such steps drain at one result a cycle when rsp
// is ready, via the four-entry result queue; cmd stalls while it holds more than two.
// A stalled rsp holds its head result; cmd keeps taking while the queue has room.
// Reset brings the sequencer to idle and the poll limits to 5 and 500.
module spi_nor_flash_command_sequencer_top import sfcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sfcs_cmd_if.sink   cmd,
	sfcs_rsp_if.source rsp,
	sfcs_cfg_if.sink   cfg
);

	in_item_t          item_s1;
	logic              valid_s1;
	logic              take, room;
	logic [POLL_W-1:0] prog_limit_q, erase_limit_q;
	push_t             push;
	out_item_t         head;

	assign take      = valid_s1 && room;
	assign cmd.ready = !valid_s1 || take;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			item_s1 <= '{func: cmd.func, address: cmd.address, length: cmd.length,
				tx_byte: cmd.tx_byte, rx_byte: cmd.rx_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_limit_q  <= PROG_LIMIT_RST;
			erase_limit_q <= ERASE_LIMIT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_PROG_LIMIT)
				prog_limit_q <= cfg.data;
			if (cfg.index == CFG_ERASE_LIMIT)
				erase_limit_q <= cfg.data;
		end
	end

	sfcs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.item       (item_s1),
		.prog_limit (prog_limit_q),
		.erase_limit(erase_limit_q),
		.push       (push)
	);

	sfcs_rsp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (rsp.valid && rsp.ready),
		.room     (room),
		.out_valid(rsp.valid),
		.out_item (head)
	);

	assign rsp.kind          = head.kind;
	assign rsp.mosi_byte     = head.mosi_byte;
	assign rsp.select_before = head.select_before;
	assign rsp.release_after = head.release_after;
	assign rsp.data_byte     = head.data_byte;
	assign rsp.success       = head.success;
	assign rsp.status_word   = head.status_word;
	assign rsp.part_id       = head.part_id;
	assign rsp.part_known    = head.part_known;
	assign rsp.last          = head.last;

endmodule
